// ===== hdl/brtt_pkg.sv =====
// Package for the beta reputation trust table.
// Holds sizes, action codes, register indexes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brtt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int COUNT_BITS    = 16;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W   = 64;
  localparam int SCORE_W = 16;
  localparam int STEP_W  = $clog2(SCORE_W);
  localparam int DEN_W   = COUNT_BITS + 2;
  localparam int CNT_PAIR_W = 2 * COUNT_BITS;

  localparam int THRESH_W = 16;
  localparam int WEIGHT_W = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  localparam logic [SCORE_W-1:0]  UNKNOWN_SCORE = SCORE_W'(32768);
  localparam logic [THRESH_W-1:0] THRESH_RESET  = THRESH_W'(32768);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = WEIGHT_W'(5);

  localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_THRESHOLD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_NEGATIVE_WEIGHT  = 1'b1;

  typedef enum logic [1:0] {
    ACT_POSITIVE = 2'd0,
    ACT_NEGATIVE = 2'd1,
    ACT_NEUTRAL  = 2'd2,
    ACT_SIGNER   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CREAD,
    ST_MISS,
    ST_DIV,
    ST_SCORE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/brtt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                                       clk,
  input  wire                                       we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                          wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/beta_reputation_trust_table.sv =====
// Top level of the beta reputation trust table.
// Depends on brtt_pkg and brtt_ram (key memory and count memory).
//
// Keeps up to TABLE_ENTRIES neighbor keys with saturating positive and negative
// counts. Feedback requests (positive, negative, neutral) look up the key and
// allocate an entry for a new key while room is left; signer requests score
// the entry as (r+1)/(r+s+2) in Q0.16 (unknown key: 0.5) and track the best
// score of the message, giving the accept verdict on the last signer. One
// request is processed at a time; every request yields one result. The key
// search reads one key memory entry per cycle, from entry 0 up to the matching
// key (through all used entries on a miss). After the search, a feedback request
// updates or allocates its entry while room is left, a known signer runs the
// 16-step restoring divider and an unknown signer takes the 0.5 score.
// The result register lets the next request be taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module beta_reputation_trust_table (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  // action [1:0], neighbor_key [65:2], zero pad above
  input  wire  [brtt_pkg::IN_TDATA_W-1:0]         in_tdata,
  input  wire                                     in_tlast,
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  // score [15:0], accept [16], table_full [17], key_found [18], zero pad above
  output logic [brtt_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast,
  input  wire                                     cfg_we,
  input  wire  [brtt_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  wire  [brtt_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  import brtt_pkg::*;

  state_t               state_r, state_nxt;
  logic [USED_W-1:0]    cmp_r, cmp_nxt;
  logic [USED_W-1:0]    cmp_plus;
  action_t              act_r, act_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic                 last_r, last_nxt;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic [SCORE_W-1:0]   best_r, best_nxt;
  logic [THRESH_W-1:0]  thr_r;
  logic [WEIGHT_W-1:0]  wgt_r;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [SCORE_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [SCORE_W-1:0]   sc_r, sc_nxt;

  logic [SCORE_W-1:0]   res_score_r, res_score_nxt;
  logic                 res_accept_r, res_accept_nxt;
  logic                 res_verdict_r, res_verdict_nxt;
  logic                 res_full_r, res_full_nxt;
  logic                 res_found_r, res_found_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]   out_score_r, out_score_nxt;
  logic                 out_accept_r, out_accept_nxt;
  logic                 out_verdict_r, out_verdict_nxt;
  logic                 out_full_r, out_full_nxt;
  logic                 out_found_r, out_found_nxt;

  logic                 key_we;
  logic [IDX_W-1:0]     key_waddr;
  logic [IDX_W-1:0]     key_raddr;
  logic [KEY_W-1:0]     key_rdata;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_waddr;
  logic [CNT_PAIR_W-1:0] cnt_wdata;
  logic [IDX_W-1:0]     cnt_raddr;
  logic [CNT_PAIR_W-1:0] cnt_rdata;

  logic [COUNT_BITS-1:0] r_cur, s_cur, r_new, s_new;
  logic [COUNT_BITS:0]   r_inc, s_add;
  logic [DEN_W-1:0]      div_sh;
  logic                  div_ge;
  logic [SCORE_W-1:0]    best_max;

  brtt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_r),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  brtt_ram #(.WIDTH(CNT_PAIR_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign cmp_plus = cmp_r + 1'b1;
  assign r_cur    = cnt_rdata[COUNT_BITS-1:0];
  assign s_cur    = cnt_rdata[CNT_PAIR_W-1:COUNT_BITS];
  assign r_inc    = {1'b0, r_cur} + 1'b1;
  assign s_add    = {1'b0, s_cur} + (COUNT_BITS + 1)'(wgt_r);
  assign r_new    = r_inc[COUNT_BITS] ? {COUNT_BITS{1'b1}} : r_inc[COUNT_BITS-1:0];
  assign s_new    = s_add[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s_add[COUNT_BITS-1:0];
  assign div_sh   = {rem_r[DEN_W-2:0], 1'b0};
  assign div_ge   = (div_sh >= den_r);
  assign best_max = (sc_r > best_r) ? sc_r : best_r;

  always_comb begin
    state_nxt       = state_r;
    cmp_nxt         = cmp_r;
    act_nxt         = act_r;
    key_nxt         = key_r;
    last_nxt        = last_r;
    used_nxt        = used_r;
    best_nxt        = best_r;
    rem_nxt         = rem_r;
    den_nxt         = den_r;
    quo_nxt         = quo_r;
    step_nxt        = step_r;
    sc_nxt          = sc_r;
    res_score_nxt   = res_score_r;
    res_accept_nxt  = res_accept_r;
    res_verdict_nxt = res_verdict_r;
    res_full_nxt    = res_full_r;
    res_found_nxt   = res_found_r;
    out_valid_nxt   = out_valid_r;
    out_score_nxt   = out_score_r;
    out_accept_nxt  = out_accept_r;
    out_verdict_nxt = out_verdict_r;
    out_full_nxt    = out_full_r;
    out_found_nxt   = out_found_r;
    in_tready       = 1'b0;
    key_we          = 1'b0;
    key_waddr       = used_r[IDX_W-1:0];
    key_raddr       = '0;
    cnt_we          = 1'b0;
    cnt_waddr       = used_r[IDX_W-1:0];
    cnt_wdata       = '0;
    cnt_raddr       = cmp_r[IDX_W-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt         = action_t'(in_tdata[1:0]);
          key_nxt         = in_tdata[KEY_W+1:2];
          last_nxt        = in_tlast;
          cmp_nxt         = '0;
          res_score_nxt   = '0;
          res_accept_nxt  = 1'b0;
          res_verdict_nxt = 1'b0;
          res_full_nxt    = 1'b0;
          res_found_nxt   = 1'b0;
          state_nxt       = (used_r == '0) ? ST_MISS : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        key_raddr = cmp_plus[IDX_W-1:0];
        if (key_rdata == key_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = ST_CREAD;
        end else if (cmp_plus == used_r) begin
          state_nxt = ST_MISS;
        end else begin
          cmp_nxt = cmp_plus;
        end
      end
      ST_CREAD: begin
        if (act_r == ACT_SIGNER) begin
          rem_nxt   = DEN_W'(r_inc);
          den_nxt   = DEN_W'(r_cur) + DEN_W'(s_cur) + DEN_W'(2);
          quo_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = cmp_r[IDX_W-1:0];
          case (act_r)
            ACT_POSITIVE: cnt_wdata = {s_cur, r_new};
            ACT_NEGATIVE: cnt_wdata = {s_new, r_cur};
            default:      cnt_wdata = {s_cur, r_cur};
          endcase
          state_nxt = ST_DONE;
        end
      end
      ST_MISS: begin
        if (act_r == ACT_SIGNER) begin
          sc_nxt    = UNKNOWN_SCORE;
          state_nxt = ST_SCORE;
        end else begin
          if (used_r < USED_W'(TABLE_ENTRIES)) begin
            key_we   = 1'b1;
            cnt_we   = 1'b1;
            used_nxt = used_r + 1'b1;
            case (act_r)
              ACT_POSITIVE: cnt_wdata = {{COUNT_BITS{1'b0}}, COUNT_BITS'(1)};
              ACT_NEGATIVE: cnt_wdata = {COUNT_BITS'(wgt_r), {COUNT_BITS{1'b0}}};
              default:      cnt_wdata = '0;
            endcase
          end else begin
            res_full_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? (div_sh - den_r) : div_sh;
        quo_nxt  = {quo_r[SCORE_W-2:0], div_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SCORE_W - 1)) begin
          sc_nxt    = {quo_r[SCORE_W-2:0], div_ge};
          state_nxt = ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (last_r) begin
          res_score_nxt   = best_max;
          res_accept_nxt  = (best_max >= thr_r);
          res_verdict_nxt = 1'b1;
          best_nxt        = '0;
        end else begin
          res_score_nxt = sc_r;
          best_nxt      = best_max;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_score_nxt   = res_score_r;
          out_accept_nxt  = res_accept_r;
          out_verdict_nxt = res_verdict_r;
          out_full_nxt    = res_full_r;
          out_found_nxt   = res_found_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_r         <= cmp_nxt;
    act_r         <= act_nxt;
    key_r         <= key_nxt;
    last_r        <= last_nxt;
    rem_r         <= rem_nxt;
    den_r         <= den_nxt;
    quo_r         <= quo_nxt;
    step_r        <= step_nxt;
    sc_r          <= sc_nxt;
    res_score_r   <= res_score_nxt;
    res_accept_r  <= res_accept_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_full_r    <= res_full_nxt;
    res_found_r   <= res_found_nxt;
    out_score_r   <= out_score_nxt;
    out_accept_r  <= out_accept_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_full_r    <= out_full_nxt;
    out_found_r   <= out_found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
      wgt_r <= WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACCEPT_THRESHOLD: thr_r <= cfg_wdata[THRESH_W-1:0];
        REG_NEGATIVE_WEIGHT:  wgt_r <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_verdict_r;
  assign out_tdata  = {(OUT_TDATA_W - SCORE_W - 3)'(0), out_found_r, out_full_r,
                       out_accept_r, out_score_r};

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |=> used_r == USED_W'($past(used_r) + 1'b1))
    else $error("allocation did not advance entry count");

  a_accept_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_verdict_r |-> !out_accept_r)
    else $error("accept without verdict");

  a_full_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_full_r && out_found_r))
    else $error("table full reported for a known key");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for beta_reputation_trust_table.
// Drives feedback and signer requests, predicts each result, checks every result field.
// Depends on brtt_pkg and the beta_reputation_trust_table RTL.
`timescale 1ns / 1ps

module tb;
  import brtt_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_ITEMS = 500;
  localparam int POOL_KEYS   = 40;
  localparam int NUM_W       = COUNT_BITS + 17;

  typedef struct packed {
    action_t            action;
    logic [KEY_W-1:0]   key;
    logic               last;
  } trust_req_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               accept;
    logic               verdict;
    logic               full;
    logic               found;
  } trust_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tlast = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  beta_reputation_trust_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Trust table copy
  logic [KEY_W-1:0]      nbr_key [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] pos_cnt [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] neg_cnt [TABLE_ENTRIES];
  int                    nbr_used = 0;
  logic [SCORE_W-1:0]    msg_best = '0;
  logic [THRESH_W-1:0]   thresh_reg = THRESH_RESET;
  logic [WEIGHT_W-1:0]   weight_reg = WEIGHT_RESET;

  trust_req_t pending_req[$];
  trust_res_t expected_res[$];
  trust_req_t offered;
  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  holdoff_arm = 1'b0;
  bit  holdoff_seen = 1'b0;
  int  holdoff_cnt = 0;
  int  fail_count = 0;
  int  cycle_count = 0;

  function automatic trust_res_t apply_request(trust_req_t rq);
    int                  slot;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    den;
    logic [NUM_W-1:0]    quo;
    logic [SCORE_W-1:0]  sc;
    logic [COUNT_BITS:0] sum;
    trust_res_t          res;
    slot = -1;
    res = '0;
    for (int i = 0; i < nbr_used; i++) begin
      if (slot < 0 && nbr_key[i] == rq.key) slot = i;
    end
    res.found = (slot >= 0);
    if (rq.action == ACT_SIGNER) begin
      sc = UNKNOWN_SCORE;
      if (slot >= 0) begin
        num = (NUM_W'(pos_cnt[slot]) + NUM_W'(1)) << 16;
        den = DEN_W'(pos_cnt[slot]) + DEN_W'(neg_cnt[slot]) + DEN_W'(2);
        quo = num / NUM_W'(den);
        sc = (quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : quo[SCORE_W-1:0];
      end
      if (sc > msg_best) msg_best = sc;
      if (rq.last) begin
        res.score = msg_best;
        res.accept = (msg_best >= thresh_reg);
        res.verdict = 1'b1;
        msg_best = '0;
      end else begin
        res.score = sc;
      end
    end else begin
      if (slot < 0) begin
        if (nbr_used < TABLE_ENTRIES) begin
          slot = nbr_used;
          nbr_used++;
          nbr_key[slot] = rq.key;
          pos_cnt[slot] = '0;
          neg_cnt[slot] = '0;
        end else begin
          res.full = 1'b1;
        end
      end
      if (slot >= 0) begin
        if (rq.action == ACT_POSITIVE) begin
          sum = {1'b0, pos_cnt[slot]} + 1'b1;
          pos_cnt[slot] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        end else if (rq.action == ACT_NEGATIVE) begin
          sum = {1'b0, neg_cnt[slot]} + weight_reg;
          neg_cnt[slot] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        end
      end
    end
    return res;
  endfunction

  function automatic void queue_req(action_t act, logic [KEY_W-1:0] key, logic last);
    trust_req_t rq;
    rq.action = act;
    rq.key = key;
    rq.last = last;
    pending_req.push_back(rq);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return {$urandom, $urandom};
    if (sel < 20) return key_pool[$urandom_range(1)];
    return key_pool[$urandom_range(POOL_KEYS - 1)];
  endfunction

  // Request driver
  always @(posedge clk) begin : request_driver
    trust_res_t res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        res = apply_request(offered);
        expected_res.push_back(res);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_req.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'({offered.key, offered.action});
          in_tlast <= offered.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin : holdoff_counter
    if (!rst_n) begin
      holdoff_cnt <= 0;
    end else if (holdoff_arm && !holdoff_seen) begin
      holdoff_cnt <= 400;
      holdoff_seen <= 1'b1;
    end else begin
      if (!holdoff_arm) holdoff_seen <= 1'b0;
      if (holdoff_cnt > 0) holdoff_cnt <= holdoff_cnt - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    trust_res_t got;
    trust_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (holdoff_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got.score = out_tdata[15:0];
        got.accept = out_tdata[16];
        got.full = out_tdata[17];
        got.found = out_tdata[18];
        got.verdict = out_tlast;
        if (expected_res.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: score=%0d accept=%0b verdict=%0b full=%0b found=%0b",
                     got.score, got.accept, got.verdict, got.full, got.found);
        end else begin
          want = expected_res.pop_front();
          if (got.score !== want.score || got.accept !== want.accept ||
              got.verdict !== want.verdict || got.full !== want.full ||
              got.found !== want.found) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp score=%0d accept=%0b verdict=%0b full=%0b found=%0b",
                       want.score, want.accept, want.verdict, want.full, want.found);
              $display("          got score=%0d accept=%0b verdict=%0b full=%0b found=%0b",
                       got.score, got.accept, got.verdict, got.full, got.found);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("beta_reputation_trust_table verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ACCEPT_THRESHOLD) thresh_reg = val;
    else weight_reg = val[WEIGHT_W-1:0];
  endtask

  task automatic drain_results();
    @(negedge clk);
    while (pending_req.size() != 0 || in_tvalid || expected_res.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic queue_burst(output int count);
    int n;
    bit cut;
    count = 0;
    if ($urandom_range(99) < 70) begin
      n = $urandom_range(1, 4);
      cut = ($urandom_range(99) < 10);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 25) begin
          queue_req(action_t'($urandom_range(2)), pick_key(), 1'($urandom_range(1)));
          count++;
        end
        queue_req(ACT_SIGNER, pick_key(), (i == n - 1) && !cut);
        count++;
      end
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        queue_req(action_t'($urandom_range(2)), pick_key(), 1'($urandom_range(1)));
        count++;
      end
    end
  endtask

  task automatic run_phase(logic [THRESH_W-1:0] thr, logic [WEIGHT_W-1:0] wgt,
                           int send_pct, int stall_pct, bit pause_mid, bit hold);
    int queued;
    int n;
    bit paused;
    write_reg(REG_ACCEPT_THRESHOLD, thr);
    write_reg(REG_NEGATIVE_WEIGHT, CFG_DATA_W'(wgt));
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    holdoff_arm = hold;
    queued = 0;
    paused = 1'b0;
    while (queued < PHASE_ITEMS) begin
      queue_burst(n);
      queued += n;
      if (pause_mid && !paused && queued >= PHASE_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    drain_results();
    holdoff_arm = 1'b0;
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] kf;
    bit dup;
    k0 = '0;
    kf = '1;
    key_pool[0] = k0;
    key_pool[1] = kf;
    for (int i = 2; i < POOL_KEYS; i++) begin
      do begin
        key_pool[i] = {$urandom, $urandom};
        dup = 1'b0;
        for (int j = 0; j < i; j++)
          if (key_pool[j] == key_pool[i]) dup = 1'b1;
      end while (dup);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: unknown key, allocation, neutral, tie at threshold
    queue_req(ACT_SIGNER, k0, 1'b1);
    queue_req(ACT_NEUTRAL, k0, 1'b0);
    queue_req(ACT_NEUTRAL, k0, 1'b1);
    queue_req(ACT_SIGNER, k0, 1'b0);
    queue_req(ACT_POSITIVE, kf, 1'b0);
    queue_req(ACT_NEGATIVE, kf, 1'b1);
    queue_req(ACT_SIGNER, kf, 1'b0);
    queue_req(ACT_SIGNER, k0, 1'b1);
    queue_req(ACT_SIGNER, kf, 1'b0);
    queue_req(ACT_POSITIVE, k0, 1'b1);
    queue_req(ACT_SIGNER, k0, 1'b1);
    queue_req(ACT_NEGATIVE, k0, 1'b0);
    queue_req(ACT_SIGNER, k0, 1'b1);
    queue_req(ACT_SIGNER, kf, 1'b1);
    drain_results();

    // Build up both counts at the largest weight, then score at the top threshold
    write_reg(REG_NEGATIVE_WEIGHT, CFG_DATA_W'(15));
    write_reg(REG_ACCEPT_THRESHOLD, 16'hFFFF);
    @(negedge clk);
    for (int i = 0; i < 60; i++) queue_req(ACT_POSITIVE, k0, 1'b0);
    for (int i = 0; i < 40; i++) queue_req(ACT_NEGATIVE, kf, 1'b0);
    queue_req(ACT_SIGNER, k0, 1'b1);
    queue_req(ACT_SIGNER, kf, 1'b1);
    queue_req(ACT_SIGNER, kf, 1'b0);
    queue_req(ACT_SIGNER, k0, 1'b1);
    drain_results();

    run_phase(16'h0000, 4'd1, 0, 0, 1'b0, 1'b1);
    run_phase(THRESH_W'($urandom_range(16384, 49152)), 4'd15, 71, 0, 1'b1, 1'b0);
    run_phase(16'hFFFF, 4'd0, 0, 71, 1'b0, 1'b0);
    run_phase(THRESH_W'($urandom_range(65535)), WEIGHT_W'($urandom_range(1, 14)),
              16, 16, 1'b0, 1'b0);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_res.size() == 0) begin
      $display("beta_reputation_trust_table verification clean");
    end else begin
      $display("beta_reputation_trust_table verification failed");
    end
    $finish;
  end

endmodule
